// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the voice allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/sva_pkg.sv
// Package of types and constants for the voice allocator.
`default_nettype none

package sva_pkg;

   localparam int NUM_VOICES_DEF = 8;

   localparam int INSTR_W = 16;
   localparam int NOTE_W  = 7;
   localparam int CHAN_W  = 4;
   localparam int PRIO_W  = 4;
   localparam int REL_W   = 3;
   localparam int OUTC_W  = 3;
   localparam int IDX_W   = 3;

   localparam logic OP_NOTE_ON = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [OUTC_W-1:0] OUT_MATCHED  = 3'd0;
   localparam logic [OUTC_W-1:0] OUT_FREE     = 3'd1;
   localparam logic [OUTC_W-1:0] OUT_STOLEN   = 3'd2;
   localparam logic [OUTC_W-1:0] OUT_REFUSED  = 3'd3;
   localparam logic [OUTC_W-1:0] OUT_RELEASED = 3'd4;

   typedef struct packed {
      logic                 active;
      logic [PRIO_W-1:0]    priority_lvl;
      logic [NOTE_W-1:0]    note;
      logic [CHAN_W-1:0]    channel;
      logic [INSTR_W-1:0]   instrument;
   } voice_entry_type;

   typedef struct packed {
      logic clear;
      logic beat;
   } scan_ctrl_type;

   typedef struct packed {
      logic match_found;
      logic free_found;
   } scan_flags_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_REL_RD,
      ST_REL_WR
   } state_type;

endpackage

`default_nettype wire

// File: rtl/synth_voice_allocator.sv
// Top level of the polyphonic voice allocator with priority stealing.
//
// The req channel carries one beat per event: a note-on request or a release
// of one voice. The rsp channel returns exactly one beat per request with the
// outcome and the voice index. Both channels use valid/ready handshakes.
// The voice table sits in a single-port-read, single-port-write memory.
// A note-on reads every voice once, one per cycle, then decides, writes
// the chosen entry, if any, and loads the result into the output register.
// A release reads the voice and writes it back, and does neither when the
// voice index lies outside the table. One request is in work at a time and
// a new beat is taken only in the idle state. A finished result waits in the
// output register while the next request is accepted and scanned; the block
// stalls before its final write only when that register is still occupied.
// Reset clears all voices to zero at once through per-entry valid bits, so
// no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module synth_voice_allocator #(
   parameter int NUM_VOICES = sva_pkg::NUM_VOICES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_operation,
   input  wire logic [sva_pkg::INSTR_W-1:0]     req_instrument_id,
   input  wire logic [sva_pkg::NOTE_W-1:0]      req_note_number,
   input  wire logic [sva_pkg::CHAN_W-1:0]      req_midi_channel,
   input  wire logic [sva_pkg::PRIO_W-1:0]      req_request_priority,
   input  wire logic [sva_pkg::REL_W-1:0]       req_release_voice,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [sva_pkg::OUTC_W-1:0]           rsp_outcome,
   output logic [sva_pkg::IDX_W-1:0]            rsp_voice_index
);
   import sva_pkg::*;

   localparam int VW = $clog2(NUM_VOICES);
   localparam int CW = $clog2(NUM_VOICES + 1);

   state_type              state_ff, state_in;
   logic [CW-1:0]          rd_cnt_ff, rd_cnt_in;
   logic                   rd_beat_ff, rd_beat_in;
   logic [VW-1:0]          rd_idx_ff;
   logic                   rel_ok_ff, rel_ok_in;

   logic [INSTR_W-1:0]     instr_ff;
   logic [NOTE_W-1:0]      note_ff;
   logic [CHAN_W-1:0]      chan_ff;
   logic [PRIO_W-1:0]      prio_ff;
   logic [REL_W-1:0]       rel_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUTC_W-1:0]      rsp_outcome_ff, rsp_outcome_in;
   logic [IDX_W-1:0]       rsp_index_ff, rsp_index_in;
   logic                   rsp_load;

   logic                   accept;
   logic                   out_free;
   logic                   mem_rd_en;
   logic [VW-1:0]          mem_rd_addr;
   voice_entry_type        mem_rd_data;
   logic                   mem_wr_en;
   logic [VW-1:0]          mem_wr_addr;
   voice_entry_type        mem_wr_data;

   scan_ctrl_type          scan_ctrl;
   scan_flags_type         scan_flags;
   logic [VW-1:0]          match_idx;
   logic [VW-1:0]          free_idx;
   logic [VW-1:0]          min_idx;
   logic [PRIO_W-1:0]      min_prio;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      rd_cnt_in      = rd_cnt_ff;
      rd_beat_in     = 1'b0;
      rel_ok_in      = rel_ok_ff;
      req_ready      = 1'b0;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = rd_cnt_ff[VW-1:0];
      mem_wr_en      = 1'b0;
      mem_wr_addr    = '0;
      mem_wr_data    = mem_rd_data;
      rsp_load       = 1'b0;
      rsp_outcome_in = OUT_REFUSED;
      rsp_index_in   = '0;
      scan_ctrl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == OP_RELEASE) begin
                  rel_ok_in = (32'(req_release_voice) < NUM_VOICES);
                  state_in  = rel_ok_in ? ST_REL_RD : ST_REL_WR;
               end else begin
                  scan_ctrl.clear = 1'b1;
                  rd_cnt_in       = '0;
                  state_in        = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_cnt_ff < CW'(NUM_VOICES)) begin
               mem_rd_en  = 1'b1;
               rd_beat_in = 1'b1;
               rd_cnt_in  = rd_cnt_ff + 1'b1;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_load         = 1'b1;
               mem_wr_data      = '{active: 1'b1, priority_lvl: prio_ff, note: note_ff,
                                    channel: chan_ff, instrument: instr_ff};
               if (scan_flags.match_found) begin
                  mem_wr_en      = 1'b1;
                  mem_wr_addr    = match_idx;
                  rsp_outcome_in = OUT_MATCHED;
                  rsp_index_in   = IDX_W'(match_idx);
               end else if (scan_flags.free_found) begin
                  mem_wr_en      = 1'b1;
                  mem_wr_addr    = free_idx;
                  rsp_outcome_in = OUT_FREE;
                  rsp_index_in   = IDX_W'(free_idx);
               end else if (min_prio > prio_ff) begin
                  rsp_outcome_in = OUT_REFUSED;
                  rsp_index_in   = '0;
               end else begin
                  mem_wr_en      = 1'b1;
                  mem_wr_addr    = min_idx;
                  rsp_outcome_in = OUT_STOLEN;
                  rsp_index_in   = IDX_W'(min_idx);
               end
               state_in = ST_IDLE;
            end
         end
         ST_REL_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = VW'(rel_ff);
            state_in    = ST_REL_WR;
         end
         ST_REL_WR: begin
            if (out_free) begin
               rsp_load           = 1'b1;
               rsp_outcome_in     = OUT_RELEASED;
               rsp_index_in       = rel_ff;
               mem_wr_en          = rel_ok_ff;
               mem_wr_addr        = VW'(rel_ff);
               mem_wr_data        = mem_rd_data;
               mem_wr_data.active = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      scan_ctrl.beat = rd_beat_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_cnt_ff    <= '0;
         rd_beat_ff   <= 1'b0;
         rel_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         rd_beat_ff   <= rd_beat_in;
         rel_ok_ff    <= rel_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_cnt_ff[VW-1:0];
      if (accept) begin
         instr_ff <= req_instrument_id;
         note_ff  <= req_note_number;
         chan_ff  <= req_midi_channel;
         prio_ff  <= req_request_priority;
         rel_ff   <= req_release_voice;
      end
      if (rsp_load) begin
         rsp_outcome_ff <= rsp_outcome_in;
         rsp_index_ff   <= rsp_index_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = rsp_outcome_ff;
   assign rsp_voice_index = rsp_index_ff;

   sva_voice_mem #(
      .NUM_VOICES (NUM_VOICES),
      .VW         (VW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   sva_scan #(
      .VW (VW)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (scan_ctrl),
      .beat_idx       (rd_idx_ff),
      .entry          (mem_rd_data),
      .key_instrument (instr_ff),
      .key_note       (note_ff),
      .key_channel    (chan_ff),
      .flags          (scan_flags),
      .match_idx      (match_idx),
      .free_idx       (free_idx),
      .min_idx        (min_idx),
      .min_prio       (min_prio)
   );

   `ASSERT_IMPLIES(a_refused_zero, clock, reset, rsp_valid && (rsp_outcome == OUT_REFUSED),
                   rsp_voice_index == '0)
   `ASSERT_NEXT(a_one_in_work, clock, reset, accept, !req_ready)
   `ASSERT_IMPLIES(a_write_place, clock, reset, mem_wr_en,
                   (state_ff == ST_DECIDE) || (state_ff == ST_REL_WR))
   `ASSERT_IMPLIES(a_load_free, clock, reset, rsp_load, !rsp_valid_ff || rsp_ready)

endmodule

`default_nettype wire

// File: rtl/sva_voice_mem.sv
// Voice table memory with one read and one write port and per-entry valid bits.
`default_nettype none

module sva_voice_mem #(
   parameter int NUM_VOICES = sva_pkg::NUM_VOICES_DEF,
   parameter int VW         = $clog2(NUM_VOICES)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     rd_en,
   input  wire logic [VW-1:0]            rd_addr,
   output sva_pkg::voice_entry_type      rd_data,
   input  wire logic                     wr_en,
   input  wire logic [VW-1:0]            wr_addr,
   input  wire sva_pkg::voice_entry_type wr_data
);
   import sva_pkg::*;

   voice_entry_type         mem [NUM_VOICES];
   logic [NUM_VOICES-1:0]   valid_ff;
   logic [NUM_VOICES-1:0]   valid_in;
   voice_entry_type         rd_data_ff;
   logic                    rd_hit_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_hit_ff  <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// File: rtl/sva_scan.sv
// Scan unit that tracks the first matching, first free and lowest-priority voice.
`default_nettype none

module sva_scan #(
   parameter int VW = $clog2(sva_pkg::NUM_VOICES_DEF)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sva_pkg::scan_ctrl_type        ctrl,
   input  wire logic [VW-1:0]                 beat_idx,
   input  wire sva_pkg::voice_entry_type      entry,
   input  wire logic [sva_pkg::INSTR_W-1:0]   key_instrument,
   input  wire logic [sva_pkg::NOTE_W-1:0]    key_note,
   input  wire logic [sva_pkg::CHAN_W-1:0]    key_channel,
   output sva_pkg::scan_flags_type            flags,
   output logic [VW-1:0]                      match_idx,
   output logic [VW-1:0]                      free_idx,
   output logic [VW-1:0]                      min_idx,
   output logic [sva_pkg::PRIO_W-1:0]         min_prio
);
   import sva_pkg::*;

   scan_flags_type      flags_ff, flags_in;
   logic                min_seen_ff, min_seen_in;
   logic [VW-1:0]       match_idx_ff, match_idx_in;
   logic [VW-1:0]       free_idx_ff, free_idx_in;
   logic [VW-1:0]       min_idx_ff, min_idx_in;
   logic [PRIO_W-1:0]   min_prio_ff, min_prio_in;
   logic                key_hit;

   assign key_hit = (entry.instrument == key_instrument) && (entry.note == key_note) &&
                    (entry.channel == key_channel);

   always_comb begin
      flags_in     = flags_ff;
      min_seen_in  = min_seen_ff;
      match_idx_in = match_idx_ff;
      free_idx_in  = free_idx_ff;
      min_idx_in   = min_idx_ff;
      min_prio_in  = min_prio_ff;
      if (ctrl.clear) begin
         flags_in    = '0;
         min_seen_in = 1'b0;
      end else if (ctrl.beat) begin
         if (!flags_ff.match_found && key_hit) begin
            flags_in.match_found = 1'b1;
            match_idx_in         = beat_idx;
         end
         if (!flags_ff.free_found && !entry.active) begin
            flags_in.free_found = 1'b1;
            free_idx_in         = beat_idx;
         end
         if (!min_seen_ff || (entry.priority_lvl < min_prio_ff)) begin
            min_seen_in = 1'b1;
            min_idx_in  = beat_idx;
            min_prio_in = entry.priority_lvl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff    <= '0;
         min_seen_ff <= 1'b0;
      end else begin
         flags_ff    <= flags_in;
         min_seen_ff <= min_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      min_idx_ff   <= min_idx_in;
      min_prio_ff  <= min_prio_in;
   end

   assign flags     = flags_ff;
   assign match_idx = match_idx_ff;
   assign free_idx  = free_idx_ff;
   assign min_idx   = min_idx_ff;
   assign min_prio  = min_prio_ff;

endmodule

`default_nettype wire

// File: dv/synth_voice_allocator_test.sv
// Self-checking testbench for the voice allocator, with a voice-table scoreboard.
`timescale 1ns / 100ps

module synth_voice_allocator_test;
   import sva_pkg::*;

   localparam int NV          = NUM_VOICES_DEF;
   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_BEATS_PER_PHASE = 580;

   typedef struct {
      logic               operation;
      logic [INSTR_W-1:0] instrument_id;
      logic [NOTE_W-1:0]  note_number;
      logic [CHAN_W-1:0]  midi_channel;
      logic [PRIO_W-1:0]  request_priority;
      logic [REL_W-1:0]   release_voice;
   } voice_request_type;

   typedef struct {
      logic [OUTC_W-1:0] outcome;
      logic [IDX_W-1:0]  voice_index;
   } alloc_result_type;

   class voice_scoreboard_type;
      voice_entry_type  voice_slots[NV];
      alloc_result_type pending[$];
      int unsigned      fail_count;

      function new();
         foreach (voice_slots[v]) voice_slots[v] = '0;
         fail_count = 0;
      endfunction

      function void note_request(voice_request_type rq);
         int               pick;
         int               lowest;
         bit               found;
         alloc_result_type res;
         pick  = 0;
         found = 1'b0;
         if (rq.operation == OP_RELEASE) begin
            if (rq.release_voice < NV) voice_slots[rq.release_voice].active = 1'b0;
            res.outcome     = OUT_RELEASED;
            res.voice_index = rq.release_voice;
         end else begin
            for (int v = 0; v < NV; v++) begin
               if (!found && voice_slots[v].instrument == rq.instrument_id &&
                   voice_slots[v].note == rq.note_number &&
                   voice_slots[v].channel == rq.midi_channel) begin
                  pick  = v;
                  found = 1'b1;
               end
            end
            res.outcome     = OUT_MATCHED;
            res.voice_index = '0;
            if (!found) begin
               for (int v = 0; v < NV; v++) begin
                  if (!found && !voice_slots[v].active) begin
                     pick  = v;
                     found = 1'b1;
                  end
               end
               res.outcome = OUT_FREE;
            end
            if (!found) begin
               lowest = 0;
               for (int v = 1; v < NV; v++) begin
                  if (voice_slots[v].priority_lvl < voice_slots[lowest].priority_lvl) lowest = v;
               end
               if (voice_slots[lowest].priority_lvl > rq.request_priority) begin
                  res.outcome = OUT_REFUSED;
               end else begin
                  pick        = lowest;
                  found       = 1'b1;
                  res.outcome = OUT_STOLEN;
               end
            end
            if (found) begin
               voice_slots[pick].active       = 1'b1;
               voice_slots[pick].priority_lvl = rq.request_priority;
               voice_slots[pick].note         = rq.note_number;
               voice_slots[pick].channel      = rq.midi_channel;
               voice_slots[pick].instrument   = rq.instrument_id;
               res.voice_index                = pick[IDX_W-1:0];
            end
         end
         pending.push_back(res);
      endfunction

      function void check_result(logic [OUTC_W-1:0] outcome, logic [IDX_W-1:0] voice_index);
         alloc_result_type exp_res;
         if (pending.size() == 0) begin
            $error("rsp beat with no request outstanding: outcome %0d voice_index %0d",
                   outcome, voice_index);
            fail_count++;
            return;
         end
         exp_res = pending.pop_front();
         if (outcome !== exp_res.outcome) begin
            $error("outcome: expected %0d, actual %0d", exp_res.outcome, outcome);
            fail_count++;
         end
         if (voice_index !== exp_res.voice_index) begin
            $error("voice_index: expected %0d, actual %0d", exp_res.voice_index, voice_index);
            fail_count++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_operation;
   logic [INSTR_W-1:0] req_instrument_id;
   logic [NOTE_W-1:0]  req_note_number;
   logic [CHAN_W-1:0]  req_midi_channel;
   logic [PRIO_W-1:0]  req_request_priority;
   logic [REL_W-1:0]   req_release_voice;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [OUTC_W-1:0]  rsp_outcome;
   logic [IDX_W-1:0]   rsp_voice_index;

   int                 req_idle_pct  = 0;
   int                 rsp_stall_pct = 0;
   int                 cycle_count   = 0;

   logic [INSTR_W-1:0] instrument_pool[4] = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'h00C3};
   logic [NOTE_W-1:0]  note_pool[4]       = '{7'd0, 7'd127, 7'd60, 7'd61};
   logic [CHAN_W-1:0]  channel_pool[3]    = '{4'd0, 4'd15, 4'd9};

   voice_scoreboard_type voice_table;

   synth_voice_allocator dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_instrument_id    (req_instrument_id),
      .req_note_number      (req_note_number),
      .req_midi_channel     (req_midi_channel),
      .req_request_priority (req_request_priority),
      .req_release_voice    (req_release_voice),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_outcome          (rsp_outcome),
      .rsp_voice_index      (rsp_voice_index)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial rsp_ready <= 1'b0;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) voice_table.check_result(rsp_outcome, rsp_voice_index);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic drive_beat(input voice_request_type rq);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_operation        <= rq.operation;
      req_instrument_id    <= rq.instrument_id;
      req_note_number      <= rq.note_number;
      req_midi_channel     <= rq.midi_channel;
      req_request_priority <= rq.request_priority;
      req_release_voice    <= rq.release_voice;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      voice_table.note_request(rq);
   endtask

   task automatic send_note(input logic [INSTR_W-1:0] instrument, input logic [NOTE_W-1:0] note,
                            input logic [CHAN_W-1:0] channel, input logic [PRIO_W-1:0] prio);
      voice_request_type rq;
      rq.operation        = OP_NOTE_ON;
      rq.instrument_id    = instrument;
      rq.note_number      = note;
      rq.midi_channel     = channel;
      rq.request_priority = prio;
      rq.release_voice    = REL_W'($urandom);
      drive_beat(rq);
   endtask

   task automatic send_release(input logic [REL_W-1:0] voice);
      voice_request_type rq;
      rq.operation        = OP_RELEASE;
      rq.instrument_id    = INSTR_W'($urandom);
      rq.note_number      = NOTE_W'($urandom);
      rq.midi_channel     = CHAN_W'($urandom);
      rq.request_priority = PRIO_W'($urandom);
      rq.release_voice    = voice;
      drive_beat(rq);
   endtask

   // Mostly pooled keys so that voices get reused, with full-range noise mixed in.
   function automatic voice_request_type random_request();
      voice_request_type rq;
      rq.operation        = ($urandom_range(99) < 25) ? OP_RELEASE : OP_NOTE_ON;
      rq.instrument_id    = ($urandom_range(99) < 80) ? instrument_pool[$urandom_range(3)]
                                                      : INSTR_W'($urandom);
      rq.note_number      = ($urandom_range(99) < 80) ? note_pool[$urandom_range(3)]
                                                      : NOTE_W'($urandom);
      rq.midi_channel     = ($urandom_range(99) < 80) ? channel_pool[$urandom_range(2)]
                                                      : CHAN_W'($urandom);
      rq.request_priority = ($urandom_range(99) < 80) ? PRIO_W'($urandom_range(10))
                                                      : PRIO_W'($urandom_range(15));
      rq.release_voice    = REL_W'($urandom_range(NV - 1));
      return rq;
   endfunction

   initial begin
      voice_table = new();
      reset                <= 1'b1;
      req_valid            <= 1'b0;
      req_operation        <= OP_NOTE_ON;
      req_instrument_id    <= '0;
      req_note_number      <= '0;
      req_midi_channel     <= '0;
      req_request_priority <= '0;
      req_release_voice    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct  = 11;
      rsp_stall_pct = 54;

      // After reset every voice holds an all-zero key, so this reuses voice 0.
      send_note(16'h0000, 7'd0, 4'd0, 4'd0);
      send_note(16'hFFFF, 7'd127, 4'd15, 4'd15);
      send_note(16'h0000, 7'd0, 4'd0, 4'd12);
      for (int v = 2; v < NV; v++) begin
         send_note(INSTR_W'(16'h1000 + v), NOTE_W'(v * 9), CHAN_W'(v), PRIO_W'(8 + v));
      end
      send_note(16'h2222, 7'd64, 4'd3, 4'd3);
      send_note(16'h2223, 7'd65, 4'd4, 4'd10);
      send_release(3'd7);
      send_release(3'd0);
      send_note(16'h3333, 7'd1, 4'd1, 4'd1);
      send_release(3'd0);
      send_note(16'h0000, 7'd0, 4'd0, 4'd5);
      send_note(16'hFFFF, 7'd127, 4'd15, 4'd0);
      send_note(16'hABCD, 7'd33, 4'd7, 4'd15);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct  = 11;
               rsp_stall_pct = 54;
            end
            1: begin
               req_idle_pct  = 54;
               rsp_stall_pct = 11;
            end
            default: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < RANDOM_BEATS_PER_PHASE; n++) drive_beat(random_request());
      end
      req_valid <= 1'b0;

      while (voice_table.pending.size() != 0) @(posedge clock);
      repeat (3 * NV + 4) @(posedge clock);
      if (voice_table.fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
